// ===== hdl/rrd_pkg.sv =====
// Package for the round-robin free-server dispatcher.
// Holds field widths, register indexes, reset values, state codes and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrd_pkg;

  // Field widths fixed by the item format.
  localparam int TIME_W  = 32;
  localparam int BUSY_W  = 33;
  localparam int COUNT_W = 16;
  localparam int SRV_W   = 4;
  localparam int MASK_W  = 16;
  localparam int CFG_W   = 5;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // Register map: one register per word.
  localparam logic REG_NUM_SERVERS = 1'b0;

  localparam logic [CFG_W-1:0]   NUM_SERVERS_RST = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_WRITE  = 3'b100
  } state_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic search;
    logic commit;
    logic any_hi;
  } rrd_ctl_t;

  // Priority token passed from one cell to the next.
  typedef struct packed {
    logic found_hi;
    logic found_lo;
  } rrd_link_t;

endpackage

`default_nettype wire

// ===== hdl/rrd_if.sv =====
// Valid/ready channel interfaces for request items and result items.
// Depends on rrd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rrd_in_if;
  import rrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] load_time;

  modport source (output valid, output arrival_time, output load_time, input ready);
  modport sink   (input valid, input arrival_time, input load_time, output ready);
endinterface

interface rrd_out_if;
  import rrd_pkg::*;

  logic               valid;
  logic               ready;
  logic [SRV_W-1:0]   assigned_server;
  logic               dropped;
  logic [COUNT_W-1:0] top_count;
  logic [MASK_W-1:0]  busiest_mask;

  modport source (output valid, output assigned_server, output dropped, output top_count,
                  output busiest_mask, input ready);
  modport sink   (input valid, input assigned_server, input dropped, input top_count,
                  input busiest_mask, output ready);
endinterface

`default_nettype wire

// ===== hdl/rrd_cell.sv =====
// One server cell of the dispatch row: busy-until time, task count and grant.
// Passes the priority token to its neighbor. Depends on rrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrd_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  rrd_pkg::rrd_ctl_t              ctl,
  input  wire  [rrd_pkg::TIME_W-1:0]     arrival,
  input  wire  [rrd_pkg::TIME_W-1:0]     load,
  input  wire  [IDX_W-1:0]               start,
  input  wire  [CNT_W-1:0]               ring_n,
  input  wire  [rrd_pkg::COUNT_W-1:0]    highest_nxt,
  input  rrd_pkg::rrd_link_t             link_in,
  output rrd_pkg::rrd_link_t             link_out,
  output logic                           grant,
  output logic [rrd_pkg::COUNT_W-1:0]    count_nxt,
  output logic                           mask_bit
);
  import rrd_pkg::*;

  logic [BUSY_W-1:0]  busy_r;
  logic [BUSY_W-1:0]  busy_nxt;
  logic [COUNT_W-1:0] count_r;
  logic               grant_r;
  logic               grant_nxt;
  logic               in_ring;
  logic               cand_lo;
  logic               cand_hi;

  // Free test and position on the ring relative to the start pointer.
  assign in_ring = CNT_W'(INDEX) < ring_n;
  assign cand_lo = in_ring && (busy_r <= {1'b0, arrival});
  assign cand_hi = cand_lo && (IDX_W'(INDEX) >= start);

  // Token chain: one pass from the start pointer up, one from server zero.
  assign link_out.found_hi = link_in.found_hi | cand_hi;
  assign link_out.found_lo = link_in.found_lo | cand_lo;

  assign grant_nxt = ctl.any_hi ? (cand_hi && !link_in.found_hi)
                                : (cand_lo && !link_in.found_lo);

  // Updated state for the commit cycle.
  assign busy_nxt  = {1'b0, arrival} + {1'b0, load};
  assign count_nxt = (grant_r && count_r != COUNT_MAX) ? count_r + 1'b1 : count_r;
  assign mask_bit  = in_ring && (count_nxt == highest_nxt);
  assign grant     = grant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      count_r <= '0;
      grant_r <= 1'b0;
    end else begin
      if (ctl.search) begin
        grant_r <= grant_nxt;
      end
      if (ctl.commit && grant_r) begin
        busy_r  <= busy_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/round_robin_free_server_dispatch.sv =====
// Round-robin free-server dispatcher, top level.
// Depends on rrd_pkg, rrd_if (rrd_in_if, rrd_out_if) and rrd_cell.
//
// Use: each request item on in_ch carries an arrival time and a load. The
// search starts at the request number modulo the ring size and takes the
// first server whose busy-until time is at or before the arrival. Each
// request yields one result item on out_ch: the server, a drop flag, the
// highest task count so far and the mask of servers in the ring that hold it.
// The APB port holds one register, num_servers, at byte address 0.
// Timing: an accepted item is searched in ST_SEARCH and committed in ST_WRITE,
// which loads the result register. The search runs through the token chain of
// the cell row; the commit updates busy time and counts and can take the next item.
// A finished result waits in the output register while the next item is taken
// and searched; a stalled receiver holds the commit, and with it in_ch.ready.
// Reset: all servers free, all counts zero, start pointer zero, ring size 16.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_free_server_dispatch #(
  parameter int MAX_SERVERS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  rrd_in_if.sink                       in_ch,
  rrd_out_if.source                    out_ch,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [rrd_pkg::APB_AW-1:0]   paddr,
  input  wire  [rrd_pkg::APB_DW-1:0]   pwdata,
  output logic [rrd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import rrd_pkg::*;

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  state_t             state_r;
  state_t             state_nxt;
  logic [CFG_W-1:0]   num_servers_r;
  logic [TIME_W-1:0]  arrival_r;
  logic [TIME_W-1:0]  load_r;
  logic [IDX_W-1:0]   start_r;
  logic [COUNT_W-1:0] highest_r;
  logic [COUNT_W-1:0] highest_nxt;
  logic               found_r;
  logic               out_valid_r;
  logic [SRV_W-1:0]   out_server_r;
  logic               out_dropped_r;
  logic [COUNT_W-1:0] out_top_r;
  logic [MASK_W-1:0]  out_mask_r;

  logic [CNT_W-1:0]   ring_n;
  logic [IDX_W-1:0]   eff_start;
  logic [IDX_W-1:0]   start_nxt;
  logic               wr_go;
  logic               in_acc;
  rrd_ctl_t           ctl;

  rrd_link_t                         link [MAX_SERVERS+1];
  logic [MAX_SERVERS-1:0]            grant_vec;
  logic [MAX_SERVERS-1:0]            mask_vec;
  logic [COUNT_W-1:0]                count_vec [MAX_SERVERS];
  logic [COUNT_W-1:0]                chosen_cnt;
  logic [IDX_W-1:0]                  chosen_idx;
  logic [31:0]                       chosen_w;
  logic [MASK_W-1:0]                 mask_out;

  // Configuration port: always ready, one register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NUM_SERVERS) ? APB_DW'(num_servers_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_servers_r <= NUM_SERVERS_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_SERVERS) begin
      num_servers_r <= pwdata[CFG_W-1:0];
    end
  end

  // Ring size clamped to 1..MAX_SERVERS, and the effective start pointer.
  always_comb begin
    if (num_servers_r == '0) begin
      ring_n = CNT_W'(1);
    end else if (32'(num_servers_r) > 32'(MAX_SERVERS)) begin
      ring_n = CNT_W'(MAX_SERVERS);
    end else begin
      ring_n = CNT_W'(num_servers_r);
    end
    eff_start = (32'(start_r) < 32'(ring_n)) ? start_r : '0;
    start_nxt = (32'(eff_start) + 32'd1 >= 32'(ring_n)) ? '0 : eff_start + 1'b1;
  end

  // Sequencer: accept, search, commit; a commit may take the next item.
  assign wr_go       = (state_r == ST_WRITE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == ST_IDLE) || wr_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_SEARCH;
      ST_SEARCH: state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (wr_go) state_nxt = in_ch.valid ? ST_SEARCH : ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign ctl.search = (state_r == ST_SEARCH);
  assign ctl.commit = wr_go;
  assign ctl.any_hi = link[MAX_SERVERS].found_hi;

  // Row of server cells with the priority token chain.
  assign link[0] = '0;

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    rrd_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .arrival     (arrival_r),
      .load        (load_r),
      .start       (eff_start),
      .ring_n      (ring_n),
      .highest_nxt (highest_nxt),
      .link_in     (link[i]),
      .link_out    (link[i+1]),
      .grant       (grant_vec[i]),
      .count_nxt   (count_vec[i]),
      .mask_bit    (mask_vec[i])
    );
  end

  // Chosen server and its new count; grants are one-hot or empty.
  always_comb begin
    chosen_idx = '0;
    chosen_cnt = '0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      if (grant_vec[i]) begin
        chosen_idx = chosen_idx | IDX_W'(i);
        chosen_cnt = chosen_cnt | count_vec[i];
      end
    end
  end

  assign chosen_w    = 32'(chosen_idx);
  assign highest_nxt = (found_r && chosen_cnt > highest_r) ? chosen_cnt : highest_r;

  // Only servers below sixteen fit in the mask.
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < MAX_SERVERS) begin : g_on
      assign mask_out[b] = mask_vec[b];
    end else begin : g_off
      assign mask_out[b] = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      highest_r   <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.search) begin
        found_r <= link[MAX_SERVERS].found_lo;
      end
      if (wr_go) begin
        start_r     <= start_nxt;
        highest_r   <= highest_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      arrival_r <= in_ch.arrival_time;
      load_r    <= in_ch.load_time;
    end
    if (wr_go) begin
      out_server_r  <= found_r ? chosen_w[SRV_W-1:0] : '0;
      out_dropped_r <= !found_r;
      out_top_r     <= highest_nxt;
      out_mask_r    <= mask_out;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.assigned_server = out_server_r;
  assign out_ch.dropped         = out_dropped_r;
  assign out_ch.top_count       = out_top_r;
  assign out_ch.busiest_mask    = out_mask_r;

  // A found request grants exactly one server; a drop grants none.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && found_r) |-> $onehot(grant_vec))
    else $error("grant not one-hot on a found request");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && !found_r) |-> (grant_vec == '0))
    else $error("grant raised on a dropped request");

  // The highest count never falls between resets.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (highest_r >= $past(highest_r)))
    else $error("highest count decreased");

  // No item is taken while a search is in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> !in_ch.ready)
    else $error("input ready during search");

endmodule

`default_nettype wire

// ===== test/round_robin_free_server_dispatch_test.sv =====
// Self-checking testbench for the round-robin free-server dispatcher.
// Drives request items and ring-size writes, and checks every result item.
// Depends on rrd_pkg, rrd_if and the round_robin_free_server_dispatch RTL.
`timescale 1ns / 1ps

module round_robin_free_server_dispatch_test;
  import rrd_pkg::*;

  localparam int MAX_SRV = 16;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 90;
  localparam int NUM_PHASES = 9;

  // One result item as the block reports it.
  typedef struct packed {
    logic [SRV_W-1:0]   server;
    logic               drop;
    logic [COUNT_W-1:0] top;
    logic [MASK_W-1:0]  mask;
  } dispatch_t;

  // Directed rows are either a request item or a ring-size write.
  typedef enum logic {ROW_REQ, ROW_RING} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [TIME_W-1:0] arrival;  // holds the ring size on a ring-size row
    logic [TIME_W-1:0] load;
    logic              typed;
    dispatch_t         want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  rrd_in_if  req_ch ();
  rrd_out_if res_ch ();

  round_robin_free_server_dispatch uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the dispatcher state.
  logic [BUSY_W-1:0]  srv_busy_until [MAX_SRV];
  logic [COUNT_W-1:0] srv_count [MAX_SRV];
  logic [COUNT_W-1:0] peak_count;
  logic [SRV_W-1:0]   next_start;
  logic [CFG_W-1:0]   ring_cfg;

  dispatch_t pending_dispatches [$];
  dir_row_t  directed_rows [$];

  int send_gap_pct;
  int recv_gap_pct;
  int stall_left;
  int mismatch_count;
  int cycle_count;

  logic [CFG_W-1:0] ring_plan [0:NUM_PHASES-1] = '{5'd5, 5'd1, 5'd16, 5'd3, 5'd31, 5'd0,
                                                   5'd12, 5'd2, 5'd9};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Computes the dispatch of one request and advances the shadow state.
  function automatic dispatch_t predict_dispatch(input logic [TIME_W-1:0] arr,
                                                 input logic [TIME_W-1:0] ld);
    int unsigned n;
    int unsigned first;
    int unsigned k;
    int unsigned idx;
    bit hit;
    dispatch_t r;
    n = (ring_cfg == 0) ? 1 : (ring_cfg > MAX_SRV) ? MAX_SRV : ring_cfg;
    first = (next_start < n) ? next_start : 0;
    hit = 1'b0;
    r = '0;
    // Walk the ring from the start pointer; equal times count as free.
    for (k = 0; k < n && !hit; k++) begin
      idx = (first + k) % n;
      if (srv_busy_until[idx] <= {1'b0, arr}) begin
        hit = 1'b1;
        r.server = idx[SRV_W-1:0];
      end
    end
    if (hit) begin
      srv_busy_until[r.server] = {1'b0, arr} + {1'b0, ld};
      if (srv_count[r.server] != COUNT_MAX) srv_count[r.server] = srv_count[r.server] + 1'b1;
      if (srv_count[r.server] > peak_count) peak_count = srv_count[r.server];
    end
    r.drop = !hit;
    next_start = (first + 1 >= n) ? '0 : SRV_W'(first + 1);
    r.top = peak_count;
    // Only servers inside the ring can show up in the mask.
    for (k = 0; k < n; k++) begin
      if (srv_count[k] == peak_count) r.mask[k] = 1'b1;
    end
    return r;
  endfunction

  // Appends one row to the end of the directed table.
  function automatic void append_row(input dir_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void add_req(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] ld);
    append_row({ROW_REQ, arr, ld, 1'b0, dispatch_t'('0)});
  endfunction

  function automatic void add_checked(input logic [TIME_W-1:0] arr,
                                      input logic [TIME_W-1:0] ld,
                                      input logic [SRV_W-1:0] srv, input logic drop,
                                      input logic [COUNT_W-1:0] top,
                                      input logic [MASK_W-1:0] mask);
    append_row({ROW_REQ, arr, ld, 1'b1, srv, drop, top, mask});
  endfunction

  function automatic void add_ring(input logic [CFG_W-1:0] value);
    append_row({ROW_RING, TIME_W'(value), {TIME_W{1'b0}}, 1'b0, dispatch_t'('0)});
  endfunction

  // Offers one request item and records its expected result on acceptance.
  task automatic send_request(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] ld,
                              input logic typed, input dispatch_t want);
    dispatch_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.arrival_time = arr;
    req_ch.load_time = ld;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_dispatch(arr, ld);
    if (typed) predicted = want;
    pending_dispatches = {pending_dispatches, predicted};
    @(negedge clk);
  endtask

  // Lowers the request valid and waits until every result has come back.
  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (pending_dispatches.size() != 0) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_ring_size(input logic [CFG_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {REG_NUM_SERVERS, 2'b00};
    pwdata = $urandom();
    pwdata[CFG_W-1:0] = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    ring_cfg = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: random ready, with an optional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      res_ch.ready = 1'b0;
      stall_left--;
    end else begin
      res_ch.ready = ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    dispatch_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_dispatches.size() == 0) begin
        $error("result item with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_dispatches.pop_front();
        check_field("assigned_server", 32'(want.server), 32'(res_ch.assigned_server));
        check_field("dropped", 32'(want.drop), 32'(res_ch.dropped));
        check_field("top_count", 32'(want.top), 32'(res_ch.top_count));
        check_field("busiest_mask", 32'(want.mask), 32'(res_ch.busiest_mask));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int ph;
    int k;
    int roll;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] ld;

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.arrival_time = '0;
    req_ch.load_time = '0;
    res_ch.ready = 1'b0;
    stall_left = 0;
    mismatch_count = 0;
    cycle_count = 0;
    send_gap_pct = 11;
    recv_gap_pct = 60;

    for (k = 0; k < MAX_SRV; k++) begin
      srv_busy_until[k] = '0;
      srv_count[k] = '0;
    end
    peak_count = '0;
    next_start = '0;
    ring_cfg = NUM_SERVERS_RST;

    // Directed part. Full ring after reset: fill servers 1..14, then an
    // all-ones request lands on server 15 and keeps it busy for good.
    add_checked(32'd0, 32'd0, 4'd0, 1'b0, 16'd1, 16'h0001);
    for (k = 1; k < 15; k++) add_req(32'd0, 32'd1);
    add_checked(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b0, 16'd1, 16'hFFFF);
    // A busy-until equal to the arrival means free.
    add_checked(32'd0, 32'd0, 4'd0, 1'b0, 16'd2, 16'h0001);
    add_req(32'd1, 32'd2);
    // Ring size zero acts as one; the pointer beyond the ring restarts at 0.
    add_ring(5'd0);
    add_req(32'd1, 32'd5);
    add_checked(32'd4, 32'd0, 4'd0, 1'b1, 16'd3, 16'h0001);
    // Oversized ring acts as the full ring.
    add_ring(5'd31);
    add_req(32'd4, 32'd0);
    add_ring(5'd2);
    add_checked(32'd3, 32'd0, 4'd0, 1'b1, 16'd3, 16'h0003);
    add_req(32'd6, 32'd10);
    add_req(32'd6, 32'd0);
    add_req(32'd7, 32'd0);
    // Highest count held outside the ring: the mask comes out empty.
    add_ring(5'd1);
    add_checked(32'd8, 32'd0, 4'd0, 1'b1, 16'd5, 16'h0000);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_RING) begin
        wait_drained();
        write_ring_size(directed_rows[i].arrival[CFG_W-1:0]);
      end else begin
        send_request(directed_rows[i].arrival, directed_rows[i].load,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random part: mostly rising arrivals with short loads, some late arrivals.
    now = 32'd64;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_ring_size(ring_plan[ph]);
      send_gap_pct = (ph < 3) ? 11 : (ph < 6) ? 60 : 0;
      recv_gap_pct = (ph < 3) ? 60 : (ph < 6) ? 11 : 0;
      // Long hold-off on results while requests keep coming.
      if (ph == 6) stall_left = 300;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          arr = now - $urandom_range(0, 40);
        end else begin
          now = now + $urandom_range(0, 6);
          arr = now;
        end
        roll = $urandom_range(99);
        ld = (roll < 5) ? 32'd0 : (roll < 85) ? $urandom_range(1, 30) : $urandom_range(31, 300);
        send_request(arr, ld, 1'b0, dispatch_t'('0));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
